// File: hw/rtl/upe_pkg.sv
// Shared constants and result type for the UDP payload extractor.
`timescale 1ns / 1ps

package upe_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 65535;

  localparam logic [15:0] MIN_FRAME    = 16'd42;
  localparam logic [15:0] ETH_HDR      = 16'd14;
  localparam logic [15:0] PROTO_OFFSET = ETH_HDR + 16'd9;
  localparam logic [15:0] IP_MIN_END   = ETH_HDR + 16'd20;
  localparam logic [7:0]  UDP_PROTO    = 8'd17;
  localparam logic [7:0]  IHL_MASK     = 8'h0F;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [6:0]  WORD_BYTES   = 7'd4;
  localparam logic [15:0] UDP_HDR      = 16'd8;

  // Byte positions inside the UDP header, relative to its start
  localparam logic [2:0] REL_SRC_HI = 3'd0;
  localparam logic [2:0] REL_SRC_LO = 3'd1;
  localparam logic [2:0] REL_DST_HI = 3'd2;
  localparam logic [2:0] REL_DST_LO = 3'd3;
  localparam logic [2:0] REL_LEN_HI = 3'd4;
  localparam logic [2:0] REL_LEN_LO = 3'd5;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic        truncated;
    logic        last_of_payload;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [7:0]  payload_byte;
  } res_t;

endpackage

// File: hw/rtl/upe_parser.sv
// Header field capture and payload selection, one frame byte per transfer.
`timescale 1ns / 1ps

module upe_parser
  import upe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        first_byte,
  input  logic [7:0]  data_byte,
  input  logic [15:0] frame_len,
  output logic        res_valid,
  output res_t        res
);

  logic [15:0] byte_offset, byte_offset_next;
  logic        frame_dropped, frame_dropped_next;
  logic [3:0]  header_words, header_words_next;
  logic [15:0] held_source_port, held_source_port_next;
  logic [15:0] held_dest_port, held_dest_port_next;
  logic [15:0] held_udp_length, held_udp_length_next;
  logic [15:0] payload_sent, payload_sent_next;

  logic [15:0] lim, off, rel, plen;
  logic [6:0]  udp_start;
  logic        len_under, pay_end, frame_end;
  logic [3:0]  cur_words;

  always_comb begin
    lim = (frame_len < 16'(MAX_FRAME_BYTES)) ? frame_len : 16'(MAX_FRAME_BYTES);
    // a new frame starts from cleared state
    off                   = first_byte ? 16'd0 : byte_offset;
    frame_dropped_next    = first_byte ? 1'b0 : frame_dropped;
    cur_words             = first_byte ? 4'd0 : header_words;
    header_words_next     = cur_words;
    held_source_port_next = first_byte ? 16'd0 : held_source_port;
    held_dest_port_next   = first_byte ? 16'd0 : held_dest_port;
    held_udp_length_next  = first_byte ? 16'd0 : held_udp_length;
    payload_sent_next     = first_byte ? 16'd0 : payload_sent;
    byte_offset_next      = (off == 16'hFFFF) ? off : off + 16'd1;

    udp_start = 7'(ETH_HDR) + 7'(cur_words) * WORD_BYTES;
    rel       = off - {9'd0, udp_start};
    len_under = held_udp_length_next < UDP_HDR;
    plen      = held_udp_length_next - UDP_HDR;
    pay_end   = !len_under && ({1'b0, payload_sent_next} + 17'd1 == {1'b0, plen});
    frame_end = ({1'b0, off} + 17'd1 == {1'b0, lim});

    res_valid           = 1'b0;
    res.payload_byte    = data_byte;
    res.source_port     = held_source_port_next;
    res.dest_port       = held_dest_port_next;
    res.last_of_payload = pay_end || frame_end;
    res.truncated       = frame_end && !pay_end;

    if (lim < MIN_FRAME) begin
      frame_dropped_next = 1'b1;
    end

    if (!frame_dropped_next && off < lim) begin
      if (off == ETH_HDR) begin
        header_words_next = 4'(data_byte & IHL_MASK);
        if (4'(data_byte & IHL_MASK) < MIN_IHL) begin
          frame_dropped_next = 1'b1;
        end
      end else if (off == PROTO_OFFSET) begin
        if (data_byte != UDP_PROTO) begin
          frame_dropped_next = 1'b1;
        end
      end else if (off >= IP_MIN_END && off >= {9'd0, udp_start}) begin
        if (rel < UDP_HDR) begin
          case (rel[2:0])
            REL_SRC_HI: held_source_port_next = {data_byte, 8'd0};
            REL_SRC_LO: held_source_port_next = held_source_port_next | {8'd0, data_byte};
            REL_DST_HI: held_dest_port_next = {data_byte, 8'd0};
            REL_DST_LO: held_dest_port_next = held_dest_port_next | {8'd0, data_byte};
            REL_LEN_HI: held_udp_length_next = {data_byte, 8'd0};
            REL_LEN_LO: begin
              held_udp_length_next = held_udp_length_next | {8'd0, data_byte};
              if ((held_udp_length_next | {8'd0, data_byte}) <= UDP_HDR) begin
                frame_dropped_next = 1'b1;
              end
            end
            default: ;
          endcase
        end else if (len_under || payload_sent_next < plen) begin
          res_valid         = in_fire;
          payload_sent_next = payload_sent_next + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      frame_dropped    <= 1'b0;
      header_words     <= '0;
      held_source_port <= '0;
      held_dest_port   <= '0;
      held_udp_length  <= '0;
      payload_sent     <= '0;
    end else if (in_fire) begin
      byte_offset      <= byte_offset_next;
      frame_dropped    <= frame_dropped_next;
      header_words     <= header_words_next;
      held_source_port <= held_source_port_next;
      held_dest_port   <= held_dest_port_next;
      held_udp_length  <= held_udp_length_next;
      payload_sent     <= payload_sent_next;
    end
  end

endmodule

// File: hw/rtl/upe_skid.sv
// Output register with a skid stage so input can flow while output stalls.
`timescale 1ns / 1ps

module upe_skid
  import upe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_valid, skid_valid;
  res_t main_data, skid_data;
  logic in_fire;

  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !main_valid) begin
      main_valid <= skid_valid || in_fire;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !main_valid) begin
      main_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

// File: hw/rtl/udp_payload_extractor.sv
// Top level: Ethernet/IPv4/UDP parser that streams out UDP payload bytes.
// Output: payload bytes reach the master side through the registered output stage.
// Throughput: one frame byte per cycle while the skid stage is empty; header capture
// updates the frame state on each transfer, and the skid stage holds one result in a stall.
// Reset: synchronous rst clears the frame state and empties the output stages;
// bytes seen before the first marked byte parse as a frame starting at offset 0.
`timescale 1ns / 1ps

module udp_payload_extractor
  import upe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // data_byte[7:0], frame_len[23:8]
  input  logic                  s_tuser,  // first_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,  // payload_byte[7:0], source_port[23:8],
                                          // dest_port[39:24]
  output logic                  m_tlast,  // last_of_payload
  output logic                  m_tuser   // truncated
);

  logic in_fire;
  logic res_valid;
  res_t res, out_res;

  assign in_fire = s_tvalid && s_tready;

  upe_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .first_byte (s_tuser),
    .data_byte  (s_tdata[7:0]),
    .frame_len  (s_tdata[23:8]),
    .res_valid  (res_valid),
    .res        (res)
  );

  upe_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (s_tready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {out_res.dest_port, out_res.source_port, out_res.payload_byte};
  assign m_tlast = out_res.last_of_payload;
  assign m_tuser = out_res.truncated;

endmodule

// File: hw/rtl/upe_checker.sv
// Port-level checks for the UDP payload extractor, bound to the top level.
`timescale 1ns / 1ps

module upe_checker
  import upe_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast,
  input logic                  m_tuser
);

  // truncation is only flagged on the closing byte
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("truncated set without last");

  // a stalled output transfer holds its contents
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output changed");

  // a new output transfer needs an input transfer the cycle before
  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("output without input");

  // input backpressure only while an output is pending
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind udp_payload_extractor upe_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: tb/udp_payload_extractor_test.sv
// Self-checking testbench for the UDP payload extractor.
`timescale 1ns / 1ps

module udp_payload_extractor_test;
  import upe_pkg::*;

  localparam int unsigned IDLE_LIMIT = 3000;  // cycles without any transfer
  localparam int unsigned HOLD_OFF   = 400;   // long receiver stall, in cycles
  localparam int unsigned DRAIN      = 10;    // cycles to wait once nothing is expected
  localparam int unsigned MAX_REPORTS = 20;
  localparam int unsigned ITEM_GOAL  = 1300;  // least input bytes queued for the whole run

  typedef struct {
    bit         first;
    logic [7:0] data;
    logic [15:0] len;
  } frame_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;   // data_byte, frame_len
  logic s_tuser = 1'b0;                 // first_byte
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // payload_byte, source_port, dest_port
  logic m_tlast;                        // last_of_payload
  logic m_tuser;                        // truncated

  udp_payload_extractor uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  frame_byte_t pending_bytes[$];
  res_t        expected_payload[$];

  // Parser state as predicted; starts cleared like the block after reset
  logic [15:0] offset_q = '0;
  bit          dropped_q = 1'b0;
  logic [3:0]  ihl_q = '0;
  logic [15:0] sport_q = '0, dport_q = '0, ulen_q = '0, sent_q = '0;

  int unsigned frames_built = 0;
  int unsigned bytes_sent = 0;
  int unsigned results_seen = 0;
  int unsigned truncated_seen = 0;
  int unsigned payload_mismatches = 0;
  int unsigned idle_cycles = 0;

  task automatic parse_byte(input frame_byte_t fb);
    int unsigned lim, off, udp_start, rel, plen;
    res_t r;
    if (fb.first) begin
      offset_q = '0;
      dropped_q = 1'b0;
      ihl_q = '0;
      sport_q = '0;
      dport_q = '0;
      ulen_q = '0;
      sent_q = '0;
    end
    off = 32'(offset_q);
    if (offset_q != 16'hFFFF) offset_q = offset_q + 16'd1;
    lim = (fb.len < MAX_FRAME_BYTES) ? fb.len : MAX_FRAME_BYTES;
    if (lim < MIN_FRAME) dropped_q = 1'b1;
    if (dropped_q || off >= lim) return;
    if (off == ETH_HDR) begin
      ihl_q = 4'(fb.data & IHL_MASK);
      if (ihl_q < MIN_IHL) dropped_q = 1'b1;
      return;
    end
    if (off == PROTO_OFFSET) begin
      if (fb.data != UDP_PROTO) dropped_q = 1'b1;
      return;
    end
    udp_start = ETH_HDR + WORD_BYTES * ihl_q;
    if (off < IP_MIN_END || off < udp_start) return;
    rel = off - udp_start;
    if (rel < UDP_HDR) begin
      case (rel)
        REL_SRC_HI: sport_q = {fb.data, 8'h00};
        REL_SRC_LO: sport_q = sport_q | {8'h00, fb.data};
        REL_DST_HI: dport_q = {fb.data, 8'h00};
        REL_DST_LO: dport_q = dport_q | {8'h00, fb.data};
        REL_LEN_HI: ulen_q = {fb.data, 8'h00};
        REL_LEN_LO: begin
          ulen_q = ulen_q | {8'h00, fb.data};
          if (ulen_q <= UDP_HDR) dropped_q = 1'b1;
        end
        default: ;
      endcase
      return;
    end
    plen = ulen_q - UDP_HDR;
    if (sent_q >= plen) return;
    r.payload_byte = fb.data;
    r.source_port = sport_q;
    r.dest_port = dport_q;
    r.last_of_payload = (sent_q + 1 == plen) || (off + 1 == lim);
    r.truncated = (off + 1 == lim) && !(sent_q + 1 == plen);
    sent_q = sent_q + 16'd1;
    expected_payload.push_back(r);
  endtask

  // Frame with IPv4/UDP header fields at their places, random bytes elsewhere
  task automatic push_frame(input bit mark, input int unsigned flen, input logic [7:0] ihl_byte,
                            input logic [7:0] proto, input logic [15:0] sport,
                            input logic [15:0] dport, input logic [15:0] ulen,
                            input int unsigned nbytes);
    int unsigned ustart;
    frame_byte_t fb;
    ustart = ETH_HDR + 4 * ihl_byte[3:0];
    for (int unsigned i = 0; i < nbytes; i++) begin
      fb.first = mark && (i == 0);
      fb.len = flen[15:0];
      fb.data = 8'($urandom);
      if (i == ETH_HDR) fb.data = ihl_byte;
      else if (i == PROTO_OFFSET) fb.data = proto;
      else if (i == ustart) fb.data = sport[15:8];
      else if (i == ustart + 1) fb.data = sport[7:0];
      else if (i == ustart + 2) fb.data = dport[15:8];
      else if (i == ustart + 3) fb.data = dport[7:0];
      else if (i == ustart + 4) fb.data = ulen[15:8];
      else if (i == ustart + 5) fb.data = ulen[7:0];
      pending_bytes.push_back(fb);
    end
    frames_built++;
  endtask

  // Sender: bursts of random length with random gaps
  frame_byte_t on_bus;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(on_bus);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_tvalid <= 1'b0;
        end else begin
          on_bus = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= on_bus.first;
          s_tdata <= {on_bus.len, on_bus.data};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // Receiver: segments of always-ready, random and mostly-stalled, plus one long hold-off
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;
  int unsigned seg_left = 0;
  int unsigned seg_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!held_once && results_seen >= 30) begin
      held_once = 1'b1;
      hold_left = HOLD_OFF;
      m_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(5, 60);
      end
      seg_left--;
      case (seg_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  res_t got, want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tlast, m_tdata};
      results_seen++;
      if (got.truncated) truncated_seen++;
      if (expected_payload.size() == 0) begin
        payload_mismatches++;
        if (payload_mismatches <= MAX_REPORTS)
          $display("%0t: extra transfer: expected none, actual %h %h %h %b %b",
                   $time, got.payload_byte, got.source_port, got.dest_port,
                   got.last_of_payload, got.truncated);
      end else begin
        want = expected_payload.pop_front();
        if (got.payload_byte !== want.payload_byte || got.source_port !== want.source_port ||
            got.dest_port !== want.dest_port || got.last_of_payload !== want.last_of_payload ||
            got.truncated !== want.truncated) begin
          payload_mismatches++;
          if (payload_mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: expected %h %h %h %b %b, actual %h %h %h %b %b",
                     $time, want.payload_byte, want.source_port, want.dest_port,
                     want.last_of_payload, want.truncated, got.payload_byte,
                     got.source_port, got.dest_port, got.last_of_payload, got.truncated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still expected",
                 $time, IDLE_LIMIT, expected_payload.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind, ihl, ulen, ustart, flen, nbytes, nlen, random_goal;
    logic [7:0] ihl_byte, proto;
    bit mark;
    frame_byte_t fb;

    // Directed frames; the first one carries no start mark right after reset
    push_frame(1'b0, 44, 8'h45, UDP_PROTO, 16'hFFFF, 16'h0000, 16'd10, 44);
    push_frame(1'b1, 60, 8'h45, UDP_PROTO, 16'h0000, 16'hFFFF, 16'd9, 62);   // padding, overrun
    push_frame(1'b1, 41, 8'h45, UDP_PROTO, 16'h1111, 16'h2222, 16'd20, 41);  // too short
    push_frame(1'b1, 60, 8'h44, UDP_PROTO, 16'h1111, 16'h2222, 16'd20, 60);  // IHL below 5
    push_frame(1'b1, 60, 8'h45, 8'h06, 16'h1111, 16'h2222, 16'd20, 60);      // not UDP
    push_frame(1'b1, 60, 8'h45, UDP_PROTO, 16'h1111, 16'h2222, 16'd8, 60);   // empty datagram
    push_frame(1'b1, 50, 8'h45, UDP_PROTO, 16'h1234, 16'h5678, 16'd30, 50);  // cut short
    push_frame(1'b1, 64, 8'h46, UDP_PROTO, 16'h8001, 16'h7FFE, 16'd20, 64);  // IP options
    push_frame(1'b1, 60, 8'h4F, UDP_PROTO, 16'h1111, 16'h2222, 16'd20, 60);  // UDP hdr past end
    push_frame(1'b1, 0, 8'h45, UDP_PROTO, 16'h1111, 16'h2222, 16'd20, 5);
    push_frame(1'b1, 65535, 8'h45, UDP_PROTO, 16'hAAAA, 16'h5555, 16'd12, 50);

    random_goal = ITEM_GOAL;
    while (pending_bytes.size() < random_goal) begin
      kind = $urandom_range(0, 9);
      ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 8) : 5;
      ulen = 9 + $urandom_range(0, 31);
      ustart = ETH_HDR + 4 * ihl;
      flen = ustart + ulen + $urandom_range(0, 8);
      nbytes = flen;
      proto = UDP_PROTO;
      ihl_byte = {4'($urandom), 4'(ihl)};
      mark = ($urandom_range(0, 15) != 0);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 3) == 0) nbytes += $urandom_range(1, 4);
          if ($urandom_range(0, 7) == 0) begin
            // large captured length: the next start mark ends the frame
            flen = $urandom_range(32768, 65535);
            nbytes = ustart + ulen + $urandom_range(0, 4);
          end
          push_frame(mark, flen, ihl_byte, proto, 16'($urandom), 16'($urandom), 16'(ulen),
                     nbytes);
        end
        6: begin
          if (ulen < 12) ulen = 12;
          flen = ustart + UDP_HDR + $urandom_range(1, ulen - 9);
          push_frame(mark, flen, ihl_byte, proto, 16'($urandom), 16'($urandom), 16'(ulen),
                     flen);
        end
        7: begin
          case ($urandom_range(0, 2))
            0: ihl_byte[3:0] = 4'($urandom_range(0, 4));
            1: begin
              proto = 8'($urandom);
              if (proto == UDP_PROTO) proto = 8'h06;
            end
            default: ulen = $urandom_range(0, 8);
          endcase
          push_frame(mark, flen, ihl_byte, proto, 16'($urandom), 16'($urandom), 16'(ulen),
                     nbytes);
        end
        8: begin
          push_frame(mark, $urandom_range(0, 41), ihl_byte, proto, 16'($urandom),
                     16'($urandom), 16'(ulen), $urandom_range(1, 60));
        end
        default: begin
          // noise: random bytes, stray start marks
          nlen = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 80);
          nbytes = $urandom_range(1, 80);
          for (int unsigned i = 0; i < nbytes; i++) begin
            fb.first = (i == 0) ? mark : ($urandom_range(0, 31) == 0);
            fb.data = 8'($urandom);
            fb.len = nlen[15:0];
            pending_bytes.push_back(fb);
          end
          frames_built++;
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || s_tvalid || expected_payload.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Drove %0d bytes in %0d frames (drops, padding, truncation, stray marks).",
             bytes_sent, frames_built);
    $display("Checked %0d payload bytes, %0d of them ending a truncated frame.",
             results_seen, truncated_seen);
    if (payload_mismatches == 0 && expected_payload.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", payload_mismatches,
               expected_payload.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
